// ----- rtl/core/bfla_pkg.sv -----
package bfla_pkg;

  // Build-time sizing of the pool.
  localparam int MAX_BUFFERS = 256;
  localparam int PAGE_BYTES  = 4096;

  // Field widths fixed by the interface.
  localparam int ADDR_W  = 48;
  localparam int PAGES_W = 9;
  localparam int COUNT_W = 9;

  // Derived widths.
  localparam int IDX_W      = (MAX_BUFFERS > 2) ? $clog2(MAX_BUFFERS) : 1;
  localparam int LIMIT_W    = IDX_W + 1;
  localparam int LINK_W     = IDX_W + 1;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES) + 1;   // stride = pages * 2 * PAGE_BYTES
  localparam int HI_W       = ADDR_W - PAGE_SHIFT;
  localparam int DIVN_W     = PAGES_W + IDX_W;
  localparam int PROD_W     = PAGES_W + IDX_W;
  localparam int STEP_W     = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // Live configuration seen by the front and back.
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [PAGES_W-1:0] pages;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic             op;
    logic             bad;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
  } res_t;

  typedef enum logic [4:0] {
    F_IDLE   = 5'b00001,
    F_OFFSET = 5'b00010,
    F_CHECK  = 5'b00100,
    F_DIV    = 5'b01000,
    F_SEND   = 5'b10000
  } front_state_t;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_EXEC = 5'b00010,
    B_POP  = 5'b00100,
    B_MUL  = 5'b01000,
    B_ADD  = 5'b10000
  } back_state_t;

endpackage

// ----- rtl/core/buffer_free_list_allocator.sv -----
// Channel   Ports                                         Transfer when
// input     push, full, in_op, in_address                 push && !full
// result    empty, pop, out_buffer_address, out_status    pop && !empty
// config    cfg_we, cfg_index, cfg_data                   cfg_we
//
// An allocate goes from capture straight to the hand-off in the front; in the back it is taken
// from the command queue, executed, has its link read when it pops a freed slot, then is scaled
// and added to the base. A free passes offset, range check (a failed check skips the divide), an
// 8-step restoring divide by the buffer size, one quotient bit per cycle, and a hand-off in the
// front, then execution in the back. The input takes the next item once the front has handed off.
// A two-entry command queue parts the front and back and results wait in a two-entry output
// queue, so the front keeps going for a few items before a stalled result side holds it.
// Reset is synchronous; the link store needs no clearing pass.
module buffer_free_list_allocator import bfla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_op,
  input  logic [ADDR_W-1:0]    in_address,
  output logic                 empty,
  input  logic                 pop,
  output logic [ADDR_W-1:0]    out_buffer_address,
  output logic [1:0]           out_status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  logic [ADDR_W-1:0]  base_r;
  logic [PAGES_W-1:0] pages_r;
  logic [COUNT_W-1:0] count_r;
  cfg_t               cfg;
  logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t               cmd_wr, cmd_rd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      pages_r <= PAGES_W'(1);
      count_r <= COUNT_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE:  base_r  <= cfg_data;
        CFG_PAGES: pages_r <= cfg_data[PAGES_W-1:0];
        CFG_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  // Slot count clamped to the built depth.
  always_comb begin
    cfg.base  = base_r;
    cfg.pages = pages_r;
    if (32'(count_r) > MAX_BUFFERS) begin
      cfg.limit = LIMIT_W'(MAX_BUFFERS);
    end else begin
      cfg.limit = LIMIT_W'(count_r);
    end
  end

  bfla_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .in_op      (in_op),
    .in_address (in_address),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_wr),
    .cmd_full   (cmd_full)
  );

  bfla_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr),
    .q_full  (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .q_empty (cmd_empty)
  );

  bfla_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd_empty          (cmd_empty),
    .cmd_data           (cmd_rd),
    .cmd_pop            (cmd_pop),
    .empty              (empty),
    .pop                (pop),
    .out_buffer_address (out_buffer_address),
    .out_status         (out_status)
  );

endmodule

// ----- rtl/core/bfla_front.sv -----
module bfla_front import bfla_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              push,
  output logic              full,
  input  logic              in_op,
  input  logic [ADDR_W-1:0] in_address,
  output logic              cmd_push,
  output cmd_t              cmd_data,
  input  logic              cmd_full
);

  front_state_t       state_r, state_nxt;
  logic               op_r, op_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic               bad_r, bad_nxt;
  logic [DIVN_W-1:0]  rem_r, rem_nxt;
  logic [DIVN_W-1:0]  div_r, div_nxt;
  logic [IDX_W-1:0]   quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [HI_W-1:0]    hi;
  logic               free_bad;

  assign full = (state_r != F_IDLE);
  assign hi   = addr_r[ADDR_W-1:PAGE_SHIFT];

  // A free is rejected when the divide leaves a remainder or the slot is past the limit.
  assign free_bad = (rem_r != '0) || ({1'b0, quo_r} >= cfg.limit);

  assign cmd_data = '{op:  op_r,
                      bad: bad_r | ((op_r == OP_FREE) & free_bad),
                      idx: quo_r};

  // Sequencer: capture; for a free, offset, range check and one quotient bit per cycle; hand-off.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    bad_nxt   = bad_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    cmd_push  = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (push) begin
          op_nxt    = in_op;
          addr_nxt  = in_address;
          bad_nxt   = 1'b0;
          rem_nxt   = '0;
          quo_nxt   = '0;
          state_nxt = (in_op == OP_FREE) ? F_OFFSET : F_SEND;
        end
      end
      F_OFFSET: begin
        addr_nxt  = addr_r - cfg.base;
        state_nxt = F_CHECK;
      end
      F_CHECK: begin
        if ((cfg.pages == '0) || (addr_r[PAGE_SHIFT-1:0] != '0) ||
            (hi >= HI_W'({cfg.pages, {IDX_W{1'b0}}}))) begin
          bad_nxt   = 1'b1;
          state_nxt = F_SEND;
        end else begin
          rem_nxt   = hi[DIVN_W-1:0];
          div_nxt   = DIVN_W'({cfg.pages, {(IDX_W-1){1'b0}}});
          step_nxt  = STEP_W'(IDX_W - 1);
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        if (rem_r >= div_r) begin
          rem_nxt = rem_r - div_r;
          quo_nxt = IDX_W'({quo_r, 1'b1});
        end else begin
          quo_nxt = IDX_W'({quo_r, 1'b0});
        end
        div_nxt  = div_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = F_SEND;
        end
      end
      F_SEND: begin
        if (!cmd_full) begin
          cmd_push  = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r   <= op_nxt;
    addr_r <= addr_nxt;
    bad_r  <= bad_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

endmodule

// ----- rtl/core/bfla_cmd_queue.sv -----
module bfla_cmd_queue import bfla_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic q_full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic q_empty
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & ~q_empty;

  // Pointer and occupancy update for each transfer.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_wr;
    rd_ptr_nxt = rd_ptr_r ^ do_rd;
    cnt_nxt    = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/bfla_back.sv -----
module bfla_back import bfla_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              cmd_empty,
  input  cmd_t              cmd_data,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output logic [ADDR_W-1:0] out_buffer_address,
  output logic [1:0]        out_status
);

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [IDX_W-1:0]   top_r, top_nxt;
  logic               nonempty_r, nonempty_nxt;
  logic [LIMIT_W-1:0] fresh_r, fresh_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;

  // Link store: next pointer of each freed slot.
  logic [LINK_W-1:0]  link_mem [MAX_BUFFERS];
  logic [LINK_W-1:0]  link_rd_r;
  logic               link_we;

  // Result queue.
  res_t               oq_mem_r [2];
  logic               oq_wr_r, oq_rd_r;
  logic [1:0]         oq_cnt_r, oq_cnt_nxt;
  logic               oq_full;
  logic               res_we;
  res_t               res_data;
  logic               res_pop;
  res_t               head;

  assign oq_full            = (oq_cnt_r == 2'd2);
  assign empty              = (oq_cnt_r == 2'd0);
  assign res_pop            = pop & ~empty;
  assign head               = oq_mem_r[oq_rd_r];
  assign out_buffer_address = head.addr;
  assign out_status         = head.status;

  // A command is only started when its result has a free slot waiting.
  assign cmd_pop = (state_r == B_IDLE) & ~cmd_empty & ~oq_full;

  // Execution sequencer for allocate and free.
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    top_nxt      = top_r;
    nonempty_nxt = nonempty_r;
    fresh_nxt    = fresh_r;
    idx_nxt      = idx_r;
    prod_nxt     = prod_r;
    link_we      = 1'b0;
    res_we       = 1'b0;
    res_data     = '{addr: '0, status: ST_OK};
    unique case (state_r)
      B_IDLE: begin
        if (cmd_pop) begin
          cmd_nxt   = cmd_data;
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        if (cmd_r.op == OP_FREE) begin
          res_we = 1'b1;
          if (cmd_r.bad) begin
            res_data.status = ST_BAD;
          end else begin
            link_we      = 1'b1;
            top_nxt      = cmd_r.idx;
            nonempty_nxt = 1'b1;
          end
          state_nxt = B_IDLE;
        end else if (nonempty_r) begin
          // Link of the top slot is read this cycle and arrives next cycle.
          idx_nxt   = top_r;
          state_nxt = B_POP;
        end else if (fresh_r < cfg.limit) begin
          idx_nxt   = fresh_r[IDX_W-1:0];
          fresh_nxt = fresh_r + 1'b1;
          state_nxt = B_MUL;
        end else begin
          res_we          = 1'b1;
          res_data.status = ST_EMPTY;
          state_nxt       = B_IDLE;
        end
      end
      B_POP: begin
        top_nxt      = link_rd_r[IDX_W-1:0];
        nonempty_nxt = link_rd_r[LINK_W-1];
        state_nxt    = B_MUL;
      end
      B_MUL: begin
        prod_nxt  = PROD_W'(idx_r) * PROD_W'(cfg.pages);
        state_nxt = B_ADD;
      end
      B_ADD: begin
        res_we        = 1'b1;
        res_data.addr = cfg.base + ADDR_W'({prod_r, {PAGE_SHIFT{1'b0}}});
        state_nxt     = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign oq_cnt_nxt = oq_cnt_r + {1'b0, res_we} - {1'b0, res_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      top_r      <= '0;
      nonempty_r <= 1'b0;
      fresh_r    <= '0;
      oq_wr_r    <= 1'b0;
      oq_rd_r    <= 1'b0;
      oq_cnt_r   <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      top_r      <= top_nxt;
      nonempty_r <= nonempty_nxt;
      fresh_r    <= fresh_nxt;
      oq_wr_r    <= oq_wr_r ^ res_we;
      oq_rd_r    <= oq_rd_r ^ res_pop;
      oq_cnt_r   <= oq_cnt_nxt;
    end
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    prod_r <= prod_nxt;
    if (res_we) begin
      oq_mem_r[oq_wr_r] <= res_data;
    end
  end

  // Link store write on a push and registered read at the stack top.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[cmd_r.idx] <= {nonempty_r, top_r};
    end
    link_rd_r <= link_mem[top_r];
  end

endmodule

// ----- rtl/core/bfla_checker.sv -----
module bfla_checker import bfla_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 push,
  input logic                 full,
  input logic                 in_op,
  input logic [ADDR_W-1:0]    in_address,
  input logic                 empty,
  input logic                 pop,
  input logic [ADDR_W-1:0]    out_buffer_address,
  input logic [1:0]           out_status,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [ADDR_W-1:0]    cfg_data
);

  // The result queue comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A waiting result carries a defined status code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status == ST_OK || out_status == ST_EMPTY || out_status == ST_BAD))
    else $error("undefined result status");

  // Failed requests report a zero address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_OK) |-> out_buffer_address == '0)
    else $error("failed request with nonzero address");

  // An accepted item keeps the input side busy in the following cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> full)
    else $error("input accepted again without processing");

endmodule

bind buffer_free_list_allocator bfla_checker u_bfla_checker (.*);

// ----- tb/buffer_free_list_allocator_checker.sv -----
`timescale 1ns / 1ps

module buffer_free_list_allocator_checker import bfla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  logic                 in_op,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [ADDR_W-1:0]    out_buffer_address,
  input  logic [1:0]           out_status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending_count
);

  // Shadow copy of the configuration registers.
  logic [ADDR_W-1:0]  pool_base;
  logic [PAGES_W-1:0] pool_pages;
  logic [COUNT_W-1:0] pool_count;

  // Shadow copy of the free stack and the untouched-slot counter.
  logic               chain_valid [MAX_BUFFERS];
  logic [IDX_W-1:0]   chain_next  [MAX_BUFFERS];
  logic [IDX_W-1:0]   freed_head;
  logic               freed_any;
  logic [LIMIT_W-1:0] untouched_next;

  res_t awaited_results[$];
  int   mismatch_count = 0;

  // Works out the result of one request and advances the shadow state.
  function automatic res_t serve_request(input logic op, input logic [ADDR_W-1:0] addr);
    res_t               r;
    logic [ADDR_W-1:0]  stride;
    logic [ADDR_W-1:0]  offset;
    logic [ADDR_W-1:0]  slot;
    logic [LIMIT_W-1:0] lim;
    logic [IDX_W-1:0]   idx;
    r.addr   = '0;
    r.status = ST_OK;
    stride   = ADDR_W'(pool_pages) * ADDR_W'(2 * PAGE_BYTES);
    lim      = (pool_count > COUNT_W'(MAX_BUFFERS)) ? LIMIT_W'(MAX_BUFFERS)
                                                     : LIMIT_W'(pool_count);
    if (op == OP_ALLOC) begin
      // The most recently freed slot goes first, then untouched slots in order.
      if (freed_any) begin
        idx        = freed_head;
        freed_any  = chain_valid[idx];
        freed_head = chain_next[idx];
        r.addr     = pool_base + ADDR_W'(idx) * stride;
      end else if (untouched_next < lim) begin
        r.addr         = pool_base + ADDR_W'(untouched_next) * stride;
        untouched_next = untouched_next + 1'b1;
      end else begin
        r.status = ST_EMPTY;
      end
    end else begin
      // The offset wraps at the address width; it must be a whole slot in range.
      offset = addr - pool_base;
      if (stride == '0 || offset % stride != '0) begin
        r.status = ST_BAD;
      end else begin
        slot = offset / stride;
        if (slot >= ADDR_W'(lim)) begin
          r.status = ST_BAD;
        end else begin
          idx              = slot[IDX_W-1:0];
          chain_valid[idx] = freed_any;
          chain_next[idx]  = freed_head;
          freed_head       = idx;
          freed_any        = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 10) begin
      $display("%0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Follows configuration writes and both channels at every clock edge.
  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      pool_base      = '0;
      pool_pages     = PAGES_W'(1);
      pool_count     = COUNT_W'(MAX_BUFFERS);
      freed_head     = '0;
      freed_any      = 1'b0;
      untouched_next = '0;
      for (int i = 0; i < MAX_BUFFERS; i++) begin
        chain_valid[i] = 1'b0;
        chain_next[i]  = '0;
      end
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE: begin
            pool_base = cfg_data;
          end
          CFG_PAGES: begin
            pool_pages = cfg_data[PAGES_W-1:0];
          end
          CFG_COUNT: begin
            pool_count = cfg_data[COUNT_W-1:0];
          end
          default: begin
          end
        endcase
      end

      // A result transfer is matched against the oldest expectation.
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: address %h status %0d",
                                    out_buffer_address, out_status));
        end else begin
          want = awaited_results.pop_front();
          if (out_buffer_address !== want.addr) begin
            report_mismatch($sformatf("buffer_address mismatch: expected %h, got %h",
                                      want.addr, out_buffer_address));
          end
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status mismatch: expected %0d, got %0d",
                                      want.status, out_status));
          end
        end
      end

      // Every request transfer yields exactly one result.
      if (push && !full) begin
        awaited_results.push_back(serve_request(in_op, in_address));
      end
    end
    pending_count <= awaited_results.size();
    fail_count    <= mismatch_count;
  end

endmodule

// ----- tb/tb_buffer_free_list_allocator.sv -----
`timescale 1ns / 1ps

module tb_buffer_free_list_allocator;
  import bfla_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic                 in_op = OP_ALLOC;
  logic [ADDR_W-1:0]    in_address = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [ADDR_W-1:0]    out_buffer_address;
  logic [1:0]           out_status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE;
  logic [ADDR_W-1:0]    cfg_data = '0;

  int fail_count;
  int pending_count;
  int requests_sent = 0;

  // Settings currently loaded, used to aim requests at real slots.
  logic [ADDR_W-1:0]  cur_base = '0;
  logic [PAGES_W-1:0] cur_pages = PAGES_W'(1);
  logic [COUNT_W-1:0] cur_count = COUNT_W'(MAX_BUFFERS);

  // Receiver stall bookkeeping.
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic calm;

  // Neither side idles during this window of requests.
  assign calm = (requests_sent >= 450) && (requests_sent < 560);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  buffer_free_list_allocator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_op              (in_op),
    .in_address         (in_address),
    .empty              (empty),
    .pop                (pop),
    .out_buffer_address (out_buffer_address),
    .out_status         (out_status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  buffer_free_list_allocator_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_op              (in_op),
    .in_address         (in_address),
    .empty              (empty),
    .pop                (pop),
    .out_buffer_address (out_buffer_address),
    .out_status         (out_status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  // Result side: random stalls, one long hold-off that lets the block fill up, none in the calm window.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && requests_sent >= 200) begin
      pop       <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= 300;
    end else if (calm) begin
      pop <= 1'b1;
    end else begin
      pop <= ($urandom_range(99) >= 34);
    end
  end

  function automatic logic [ADDR_W-1:0] slot_address(input int k);
    return cur_base + ADDR_W'(k) * (ADDR_W'(cur_pages) * ADDR_W'(2 * PAGE_BYTES));
  endfunction

  function automatic logic [ADDR_W-1:0] random_address();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[ADDR_W-1:0];
  endfunction

  // Offers one request, with an optional random gap first, until its transfer.
  task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr);
    if (!calm && $urandom_range(99) < 34) begin
      push <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 34);
    end
    push       <= 1'b1;
    in_op      <= op;
    in_address <= addr;
    @(posedge clk);
    while (full) @(posedge clk);
    requests_sent <= requests_sent + 1;
  endtask

  // Waits until every result has come back and the block is quiet.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic load_settings(input logic [ADDR_W-1:0] base,
                               input logic [PAGES_W-1:0] pages,
                               input logic [COUNT_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= CFG_PAGES;
    cfg_data  <= ADDR_W'(pages);
    @(posedge clk);
    cfg_index <= CFG_COUNT;
    cfg_data  <= ADDR_W'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_base  = base;
    cur_pages = pages;
    cur_count = count;
  endtask

  // Mostly allocations and frees of real slots, plus malformed frees and noise.
  task automatic random_requests(input int n);
    int lim;
    int roll;
    int k;
    for (int i = 0; i < n; i++) begin
      lim  = (cur_count > COUNT_W'(MAX_BUFFERS)) ? MAX_BUFFERS : int'(cur_count);
      k    = (lim == 0) ? $urandom_range(3) : $urandom_range(lim - 1);
      roll = $urandom_range(99);
      if (roll < 50) begin
        send_request(OP_ALLOC, random_address());
      end else if (roll < 85) begin
        send_request(OP_FREE, slot_address(k));
      end else if (roll < 92) begin
        send_request(OP_FREE, slot_address(k) + ADDR_W'($urandom_range(1, 2 * PAGE_BYTES - 1)));
      end else if (roll < 96) begin
        send_request(OP_FREE, slot_address(lim + $urandom_range(300)));
      end else begin
        send_request(OP_FREE, random_address());
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: fresh slots, misaligned, out of range, double free.
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '1);
    send_request(OP_FREE, slot_address(1));
    send_request(OP_FREE, slot_address(1) + ADDR_W'(1));
    send_request(OP_FREE, slot_address(MAX_BUFFERS));
    send_request(OP_FREE, '1);
    send_request(OP_FREE, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, slot_address(5));
    send_request(OP_FREE, slot_address(5));
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    random_requests(150);

    // Top base so slot addresses wrap, 256 pages, count lowered in use.
    settle();
    load_settings('1, PAGES_W'(256), COUNT_W'(4));
    repeat (5) send_request(OP_ALLOC, random_address());
    send_request(OP_FREE, slot_address(3));
    send_request(OP_ALLOC, '0);
    random_requests(150);

    // Zero pages: every slot sits at the base and every free is refused.
    settle();
    load_settings(random_address(), '0, COUNT_W'(1));
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, cur_base);
    random_requests(100);

    // Zero count with the widest page field.
    settle();
    load_settings('0, '1, '0);
    send_request(OP_ALLOC, '1);
    send_request(OP_FREE, '0);
    random_requests(100);

    // Random base and size, count above the built depth.
    settle();
    load_settings(random_address(), PAGES_W'($urandom_range(1, 256)), '1);
    random_requests(150);

    // Small pool at the smallest size.
    settle();
    load_settings(random_address(), PAGES_W'(1), COUNT_W'(2));
    random_requests(100);

    settle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
